>>> rtl/btoc_pkg.sv
package btoc_pkg;

	localparam int MAP_DEPTH   = 32768;
	localparam int MAP_AW      = $clog2(MAP_DEPTH);
	localparam int TABLE_DEPTH = 1024;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = 32;
	localparam int BASE_W      = 16;
	localparam int SEL_W       = 10;

	localparam logic [BASE_W-1:0] MAP_BASE_RESET = 16'h0400;
	localparam logic [USED_W-1:0] NO_SLOT        = USED_W'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		KIND_RECORD = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_SLOT,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic map_rd;
		logic slot_rd;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_blocked;
	} status_t;

endpackage

>>> rtl/btoc_req_if.sv
interface btoc_req_if;
	import btoc_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [ADDR_W-1:0]  target_address;
	logic [SEL_W-1:0]   slot_select;

	modport source (output valid, kind, target_address, slot_select, input ready);
	modport sink   (input valid, kind, target_address, slot_select, output ready);

endinterface

>>> rtl/btoc_rsp_if.sv
interface btoc_rsp_if;
	import btoc_pkg::*;

	logic               valid;
	logic               ready;
	logic [USED_W-1:0]  slot_index;
	logic [ADDR_W-1:0]  stored_address;
	logic [CNT_W-1:0]   visit_count;
	logic               newly_allocated;
	logic               out_of_range;
	logic               table_full;
	logic [USED_W-1:0]  slots_used;

	modport source (output valid, slot_index, stored_address, visit_count,
		newly_allocated, out_of_range, table_full, slots_used, input ready);
	modport sink   (input valid, slot_index, stored_address, visit_count,
		newly_allocated, out_of_range, table_full, slots_used, output ready);

endinterface

>>> rtl/branch_target_occurrence_counter_core.sv
// Branch target occurrence counter.
// req channel: kind, target_address, slot_select. kind record counts a target
// in a direct-mapped map indexed by (low 16 address bits - map_base), giving
// the first visit the next free slot; lookup finds the slot of an address;
// read reports a slot by number.
// rsp channel: one result item per request item (slot, stored address, count,
// allocation/out-of-range/full flags, slots in use).
// cfg_we/cfg_wdata write map_base; the user must write it only while the block
// is idle, which the block itself does not enforce.
// Steps: an item is accepted in the idle state, then goes through the map read,
// the slot table read and the update, which loads the result into the output
// register. The block takes a new item only once the previous one has finished
// its update.
// Reset: slots in use go to zero and map_base to 0x400; req.ready then stays
// low while the map is swept to zero, one entry a cycle. Map entries are
// checked against a back pointer in the slot table.
// A stalled rsp holds its result in the output register; the next item is
// still accepted and waits in its update step until the register frees.
module branch_target_occurrence_counter_core
	import btoc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BASE_W-1:0] cfg_wdata,
	btoc_req_if.sink          req,
	btoc_rsp_if.source        rsp
);

	cmd_t    cmd;
	status_t stat;
	logic    in_ready;

	assign req.ready = in_ready;

	btoc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	btoc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.kind           (req.kind),
		.target_address (req.target_address),
		.slot_select    (req.slot_select),
		.rsp            (rsp)
	);

endmodule

>>> rtl/btoc_ctrl.sv
module btoc_ctrl
	import btoc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t stat,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				// one map entry per cycle after reset
				cmd.clear = 1'b1;
				if (stat.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map_rd = 1'b1;
				state_nxt  = ST_SLOT;
			end
			ST_SLOT: begin
				cmd.slot_rd = 1'b1;
				state_nxt   = ST_UPD;
			end
			ST_UPD: begin
				// hold the finished item until the output register can take it
				if (!stat.out_blocked) begin
					cmd.update = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/btoc_datapath.sv
module btoc_datapath
	import btoc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            stat,
	input  logic               cfg_we,
	input  logic [BASE_W-1:0]  cfg_wdata,
	input  logic [1:0]         kind,
	input  logic [ADDR_W-1:0]  target_address,
	input  logic [SEL_W-1:0]   slot_select,
	btoc_rsp_if.source         rsp
);

	logic [BASE_W-1:0] base_q;
	kind_t             kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SEL_W-1:0]  sel_q;
	logic [BASE_W-1:0] mi_q;
	logic [USED_W-1:0] used_q;
	logic [MAP_AW-1:0] clr_q;

	logic [SLOT_W-1:0] map_mem [MAP_DEPTH];
	logic [SLOT_W-1:0] map_rd_q;

	logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
	logic [CNT_W-1:0]  cnt_mem  [TABLE_DEPTH];
	logic [MAP_AW-1:0] back_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] addr_rd_q;
	logic [CNT_W-1:0]  cnt_rd_q;
	logic [MAP_AW-1:0] back_rd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_sel;

	logic              out_valid_q;
	logic [USED_W-1:0] o_slot_q;
	logic [ADDR_W-1:0] o_addr_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic              o_new_q;
	logic              o_oor_q;
	logic              o_full_q;
	logic [USED_W-1:0] o_used_q;

	logic              oor;
	logic              slot_ok;
	logic              hit;
	logic              room;
	logic              do_inc;
	logic              do_alloc;
	logic [CNT_W-1:0]  cnt_inc;
	logic              cnt_we;
	logic [SLOT_W-1:0] cnt_wa;
	logic [CNT_W-1:0]  cnt_wd;
	logic              present;
	logic [USED_W-1:0] r_slot;
	logic [ADDR_W-1:0] r_addr;
	logic [CNT_W-1:0]  r_cnt;
	logic              r_new;
	logic              r_oor;
	logic              r_full;
	logic [USED_W-1:0] used_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= MAP_BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + MAP_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(kind);
			addr_q <= target_address;
			sel_q  <= slot_select;
			mi_q   <= target_address[BASE_W-1:0] - base_q;
		end
	end

	// the map is swept to zero after reset so every read is defined; an entry
	// counts only if its slot is allocated and that slot points back at the
	// same map index
	always_ff @(posedge clk) begin
		if (cmd.map_rd) begin
			map_rd_q <= map_mem[mi_q[MAP_AW-1:0]];
		end
		if (cmd.clear) begin
			map_mem[clr_q] <= '0;
		end else if (do_alloc) begin
			map_mem[mi_q[MAP_AW-1:0]] <= used_q[SLOT_W-1:0];
		end
	end

	assign slot_sel = (kind_q == KIND_READ) ? sel_q : map_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.slot_rd) begin
			slot_q    <= slot_sel;
			addr_rd_q <= addr_mem[slot_sel];
			cnt_rd_q  <= cnt_mem[slot_sel];
			back_rd_q <= back_mem[slot_sel];
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc) begin
			addr_mem[used_q[SLOT_W-1:0]] <= addr_q;
			back_mem[used_q[SLOT_W-1:0]] <= mi_q[MAP_AW-1:0];
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
	end

	always_comb begin
		oor      = (32'(mi_q) >= MAP_DEPTH);
		slot_ok  = {1'b0, slot_q} < used_q;
		hit      = slot_ok && (back_rd_q == mi_q[MAP_AW-1:0]);
		room     = used_q < USED_W'(TABLE_DEPTH);
		cnt_inc  = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + CNT_W'(1);
		do_inc   = cmd.update && (kind_q == KIND_RECORD) && !oor && hit;
		do_alloc = cmd.update && (kind_q == KIND_RECORD) && !oor && !hit && room;
		cnt_we   = do_inc || do_alloc;
		cnt_wa   = do_alloc ? used_q[SLOT_W-1:0] : slot_q;
		cnt_wd   = do_alloc ? CNT_W'(1) : cnt_inc;
		used_nxt = do_alloc ? used_q + USED_W'(1) : used_q;

		present = 1'b0;
		r_slot  = {1'b0, slot_q};
		r_addr  = addr_rd_q;
		r_cnt   = cnt_rd_q;
		r_new   = 1'b0;
		r_oor   = 1'b0;
		r_full  = 1'b0;
		case (kind_q)
			KIND_RECORD: begin
				r_oor = oor;
				if (!oor && hit) begin
					present = 1'b1;
					r_cnt   = cnt_inc;
				end else if (!oor && room) begin
					present = 1'b1;
					r_new   = 1'b1;
					r_slot  = used_q;
					r_addr  = addr_q;
					r_cnt   = CNT_W'(1);
				end else if (!oor) begin
					r_full = 1'b1;
				end
			end
			KIND_LOOKUP: begin
				r_oor   = oor;
				present = !oor && hit && (addr_rd_q == addr_q);
			end
			KIND_READ: begin
				present = slot_ok;
			end
			default: begin
				present = 1'b0;
			end
		endcase
		if (!present) begin
			r_slot = NO_SLOT;
			r_addr = '0;
			r_cnt  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			used_q <= used_nxt;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			o_slot_q <= r_slot;
			o_addr_q <= r_addr;
			o_cnt_q  <= r_cnt;
			o_new_q  <= r_new;
			o_oor_q  <= r_oor;
			o_full_q <= r_full;
			o_used_q <= used_nxt;
		end
	end

	assign stat = '{
		clear_done:  (clr_q == MAP_AW'(MAP_DEPTH - 1)),
		out_blocked: out_valid_q && !rsp.ready
	};

	assign rsp.valid            = out_valid_q;
	assign rsp.slot_index       = o_slot_q;
	assign rsp.stored_address   = o_addr_q;
	assign rsp.visit_count      = o_cnt_q;
	assign rsp.newly_allocated  = o_new_q;
	assign rsp.out_of_range     = o_oor_q;
	assign rsp.table_full       = o_full_q;
	assign rsp.slots_used       = o_used_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("slot count beyond table depth");

	a_alloc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_alloc |=> used_q == $past(used_q) + USED_W'(1))
		else $error("allocation did not advance slot count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && out_valid_q |-> rsp.ready)
		else $error("result overwritten while held");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && r_full |-> used_q == USED_W'(TABLE_DEPTH))
		else $error("table full flagged with free slots");

endmodule
